/* hw/rtl/crb_pkg.sv */
// crb_pkg: shared constants, status codes and word types of the cubic bisection root finder
// depends on nothing; imported by cubic_bisection_root
package crb_pkg;

    localparam int VALUE_WIDTH     = 24;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int STEPS_W         = 5;
    localparam int STATUS_W        = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [STEPS_W-1:0]     STEP_LIMIT    = 5'd25;
    localparam logic [VALUE_WIDTH-1:0] TOL_RESET     = 24'd66;

    // register index, taken from paddr[2]
    localparam logic                   REG_TOLERANCE = 1'b0;

    localparam logic [STATUS_W-1:0]    STAT_WIDTH    = 2'd0;
    localparam logic [STATUS_W-1:0]    STAT_ZERO     = 2'd1;
    localparam logic [STATUS_W-1:0]    STAT_BAD      = 2'd2;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] lower_end;
        logic signed [VALUE_WIDTH-1:0] upper_end;
    } operand_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] root;
        logic [STATUS_W-1:0]           status;
        logic [STEPS_W-1:0]            steps;
    } result_t;

endpackage

/* hw/rtl/cubic_bisection_root.sv */
// cubic_bisection_root: bisection search for a root of x^3 - x - 1 over a Q8.16 bracket
// depends on crb_pkg; one shared unsigned multiplier under a one-hot sequencer
// each cubic evaluation runs three products on the one shared multiplier,
// two wide accumulate steps and a sign decision; the endpoint checks take two evaluations
// throughput: one word at a time, busy high until done; a new start is taken while done is high
// reset: rst_n clears the sequencer, the done strobe and sets tolerance to 66
// the receiver cannot stall: result is valid for the single cycle that done is high
module cubic_bisection_root #(
    parameter int FRAC_BITS = crb_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  crb_pkg::operand_t          operand,
    output logic                       busy,
    output logic                       done,
    output crb_pkg::result_t           result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [crb_pkg::PADDR_W-1:0] paddr,
    input  logic [crb_pkg::PDATA_W-1:0] pwdata,
    output logic [crb_pkg::PDATA_W-1:0] prdata,
    output logic                       pready
);
    import crb_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int T_CUBE = 3 * W;
    localparam int T_LIN  = W + 2 * FRAC_BITS;
    localparam int T_ONE  = 3 * FRAC_BITS + 1;
    localparam int T_MAX  = (T_CUBE > T_LIN) ? ((T_CUBE > T_ONE) ? T_CUBE : T_ONE)
                                             : ((T_LIN > T_ONE) ? T_LIN : T_ONE);
    localparam int CW     = T_MAX + 2;

    localparam logic [CW-1:0] ONE_CUBED = CW'(1) << (3 * FRAC_BITS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQ   = 8'b0000_0010,
        S_LO   = 8'b0000_0100,
        S_HI   = 8'b0000_1000,
        S_CUBE = 8'b0001_0000,
        S_FIN  = 8'b0010_0000,
        S_EVAL = 8'b0100_0000,
        S_STEP = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } phase_t;

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic [W-1:0]          tol_reg, tol_next;
    logic signed [W-1:0]   a_reg, a_next;
    logic signed [W-1:0]   b_reg, b_next;
    logic signed [W-1:0]   x_reg, x_next;
    logic [STEPS_W-1:0]    steps_reg, steps_next;
    logic                  sa_neg_reg, sa_neg_next;
    logic                  sa_zero_reg, sa_zero_next;
    logic [2*W-1:0]        prod_reg, prod_next;
    logic [W-1:0]          sqhi_reg, sqhi_next;
    logic [CW-1:0]         acc_reg, acc_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic [W-1:0]          mag;
    logic [W-1:0]          mul_a;
    logic [2*W-1:0]        mul_p;
    logic [CW-1:0]         lin_term;
    logic [CW-1:0]         acc_signed;
    logic signed [W:0]     pair_sum;
    logic signed [W:0]     pair_diff;
    logic [W:0]            span;
    logic signed [W-1:0]   mid;
    logic                  narrow;
    logic                  acc_neg;
    logic                  acc_zero;
    logic                  cfg_write;

    // magnitude of the operand under evaluation
    assign mag = x_reg[W-1] ? (~x_reg + W'(1)) : x_reg;

    // shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_LO:    mul_a = prod_reg[W-1:0];
            S_HI:    mul_a = sqhi_reg;
            default: mul_a = mag;
        endcase
    end
    assign mul_p = mul_a * mag;

    assign lin_term   = CW'(mag) << (2 * FRAC_BITS);
    assign acc_signed = x_reg[W-1] ? (~acc_reg + CW'(1)) : acc_reg;
    assign acc_neg    = acc_reg[CW-1];
    assign acc_zero   = (acc_reg == '0);

    // bracket midpoint and width
    assign pair_sum  = {a_reg[W-1], a_reg} + {b_reg[W-1], b_reg};
    assign mid       = pair_sum[W:1];
    assign pair_diff = {a_reg[W-1], a_reg} - {b_reg[W-1], b_reg};
    assign span      = pair_diff[W] ? (~pair_diff + (W+1)'(1)) : pair_diff;
    assign narrow    = span < {1'b0, tol_reg};

    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        tol_next     = tol_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        x_next       = x_reg;
        steps_next   = steps_reg;
        sa_neg_next  = sa_neg_reg;
        sa_zero_next = sa_zero_reg;
        prod_next    = prod_reg;
        sqhi_next    = sqhi_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        if (cfg_write && (paddr[2] == REG_TOLERANCE))
        begin
            tol_next = pwdata[W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    a_next     = operand.lower_end;
                    b_next     = operand.upper_end;
                    x_next     = operand.lower_end;
                    steps_next = '0;
                    phase_next = PH_A;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                prod_next  = mul_p;
                state_next = S_LO;
            end
            S_LO:
            begin
                sqhi_next  = prod_reg[2*W-1:W];
                prod_next  = mul_p;
                state_next = S_HI;
            end
            S_HI:
            begin
                acc_next   = CW'(prod_reg);
                prod_next  = mul_p;
                state_next = S_CUBE;
            end
            S_CUBE:
            begin
                acc_next   = acc_reg + (CW'(prod_reg) << W) - lin_term;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                acc_next   = acc_signed - ONE_CUBED;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                unique case (phase_reg)
                    PH_A:
                    begin
                        sa_neg_next  = acc_neg;
                        sa_zero_next = acc_zero;
                        x_next       = b_reg;
                        phase_next   = PH_B;
                        state_next   = S_SQ;
                    end
                    PH_B:
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        result_next.steps = '0;
                        if (sa_zero_reg)
                        begin
                            result_next.root   = a_reg;
                            result_next.status = STAT_ZERO;
                        end
                        else if (acc_zero)
                        begin
                            result_next.root   = b_reg;
                            result_next.status = STAT_ZERO;
                        end
                        else if (sa_neg_reg == acc_neg)
                        begin
                            result_next.root   = '0;
                            result_next.status = STAT_BAD;
                        end
                        else if (narrow)
                        begin
                            result_next.root   = mid;
                            result_next.status = STAT_WIDTH;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_STEP;
                        end
                    end
                    PH_C:
                    begin
                        if (acc_zero)
                        begin
                            result_next.root   = x_reg;
                            result_next.status = STAT_ZERO;
                            result_next.steps  = steps_reg;
                            done_next          = 1'b1;
                            state_next         = S_IDLE;
                        end
                        else
                        begin
                            if (acc_neg == sa_neg_reg)
                            begin
                                a_next = x_reg;
                            end
                            else
                            begin
                                b_next = x_reg;
                            end
                            state_next = S_STEP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_STEP:
            begin
                if (!narrow && (steps_reg < STEP_LIMIT))
                begin
                    x_next     = mid;
                    steps_next = steps_reg + STEPS_W'(1);
                    phase_next = PH_C;
                    state_next = S_SQ;
                end
                else
                begin
                    result_next.root   = x_reg;
                    result_next.status = STAT_WIDTH;
                    result_next.steps  = steps_reg;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_A;
            tol_reg   <= TOL_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tol_reg   <= tol_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg       <= a_next;
        b_reg       <= b_next;
        x_reg       <= x_next;
        steps_reg   <= steps_next;
        sa_neg_reg  <= sa_neg_next;
        sa_zero_reg <= sa_zero_next;
        prod_reg    <= prod_next;
        sqhi_reg    <= sqhi_next;
        acc_reg     <= acc_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOLERANCE) ? PDATA_W'(tol_reg) : '0;

endmodule

/* dv/cubic_bisection_root_test.sv */
// cubic_bisection_root_test: self-checking bench for the cubic bisection root finder,
// directed brackets and tolerance extremes, then random brackets with and without sender idling
// depends on crb_pkg and cubic_bisection_root; results checked against an in-bench predictor
module cubic_bisection_root_test;
    import crb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ROOT_RAW = 86817;
    localparam int VALUE_MAX = 8388607;
    localparam int VALUE_MIN = -8388608;
    localparam logic [PADDR_W-1:0] TOL_ADDR = {REG_TOLERANCE, 2'b00};

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    operand_t operand = '0;
    logic busy;
    logic done;
    result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    result_t expected_results[$];
    logic [VALUE_WIDTH-1:0] tolerance_setting = TOL_RESET;
    int mismatch_count = 0;
    int cycle_count = 0;

    cubic_bisection_root u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .operand (operand),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cubic_bisection_root regression: fail");
            $finish;
        end
    end

    // exact sign of x^3 - x - 1 with x in raw fixed point
    function automatic int cubic_sign(logic signed [VALUE_WIDTH-1:0] x);
        logic signed [127:0] wx;
        logic signed [127:0] f;
        wx = x;
        f = wx * wx * wx - (wx <<< (2 * FRAC_BITS_DEF)) - (128'sd1 <<< (3 * FRAC_BITS_DEF));
        if (f < 0)
            return -1;
        if (f == 0)
            return 0;
        return 1;
    endfunction

    function automatic longint span_of(longint a, longint b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic result_t predict_root(operand_t op, logic [VALUE_WIDTH-1:0] tol);
        longint a;
        longint b;
        longint c;
        longint tol_l;
        int sa;
        int sb;
        int sc;
        int n;
        result_t r;
        a = op.lower_end;
        b = op.upper_end;
        tol_l = longint'(tol);
        c = 0;
        n = 0;
        r.status = STAT_WIDTH;
        sa = cubic_sign(op.lower_end);
        sb = cubic_sign(op.upper_end);
        if (sa == 0)
        begin
            c = a;
            r.status = STAT_ZERO;
        end
        else if (sb == 0)
        begin
            c = b;
            r.status = STAT_ZERO;
        end
        else if (sa == sb)
        begin
            c = 0;
            r.status = STAT_BAD;
        end
        else if (span_of(a, b) < tol_l)
        begin
            c = (a + b) >>> 1;
        end
        else
        begin
            while (span_of(a, b) >= tol_l && n < STEP_LIMIT)
            begin
                c = (a + b) >>> 1;
                n++;
                sc = cubic_sign(c[VALUE_WIDTH-1:0]);
                if (sc == 0)
                begin
                    r.status = STAT_ZERO;
                    break;
                end
                if (sc == sa)
                    a = c;
                else
                    b = c;
            end
        end
        r.root = c[VALUE_WIDTH-1:0];
        r.steps = n[STEPS_W-1:0];
        return r;
    endfunction

    function automatic operand_t make_bracket(int lo, int hi);
        operand_t op;
        op.lower_end = lo[VALUE_WIDTH-1:0];
        op.upper_end = hi[VALUE_WIDTH-1:0];
        return op;
    endfunction

    // magnitude spread over all scales, capped
    function automatic int random_mag(int cap);
        int m;
        m = $urandom_range((1 << $urandom_range(23)) - 1);
        return (m > cap) ? cap : m;
    endfunction

    function automatic operand_t random_bracket();
        int kind;
        int lo;
        int hi;
        int tmp;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            lo = ROOT_RAW - 1 - random_mag(VALUE_MAX);
            hi = ROOT_RAW + random_mag(VALUE_MAX - ROOT_RAW);
        end
        else if (kind < 90)
        begin
            if ($urandom_range(1))
            begin
                lo = ROOT_RAW + random_mag(VALUE_MAX - ROOT_RAW);
                hi = ROOT_RAW + random_mag(VALUE_MAX - ROOT_RAW);
            end
            else
            begin
                lo = ROOT_RAW - 1 - random_mag(VALUE_MAX);
                hi = ROOT_RAW - 1 - random_mag(VALUE_MAX);
            end
        end
        else
        begin
            lo = $urandom();
            hi = $urandom();
        end
        if ($urandom_range(1))
        begin
            tmp = lo;
            lo = hi;
            hi = tmp;
        end
        return make_bracket(lo, hi);
    endfunction

    // result checker, sampled mid-cycle
    always @(negedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result root %0d status %0d steps %0d", $time,
                    result.root, result.status, result.steps);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.root !== want.root)
                begin
                    $display("%0t: root expected %0d actual %0d", $time, want.root, result.root);
                    mismatch_count++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                        result.status);
                    mismatch_count++;
                end
                if (result.steps !== want.steps)
                begin
                    $display("%0t: steps expected %0d actual %0d", $time, want.steps,
                        result.steps);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic add_expected(result_t r);
        expected_results = {expected_results, r};
    endtask

    // leaves start high; the caller lowers it or sends the next word
    task automatic send_word(operand_t op);
        logic taken;
        start <= 1'b1;
        operand <= op;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        add_expected(predict_root(op, tolerance_setting));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [VALUE_WIDTH-1:0] value);
        logic [PDATA_W-1:0] data;
        drain();
        data = $urandom();
        data[VALUE_WIDTH-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TOL_ADDR;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tolerance_setting = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[VALUE_WIDTH-1:0] !== tolerance_setting)
        begin
            $display("%0t: tolerance readback expected %0d actual %0d", $time,
                tolerance_setting, prdata[VALUE_WIDTH-1:0]);
            mismatch_count++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // reset tolerance: field extremes, bad brackets, narrow start, width at the tolerance
    task automatic test_directed_brackets();
        send_word(make_bracket(0, 2 * 65536));
        send_word(make_bracket(VALUE_MIN, VALUE_MAX));
        send_word(make_bracket(VALUE_MAX, VALUE_MIN));
        send_word(make_bracket(VALUE_MIN, VALUE_MIN));
        send_word(make_bracket(VALUE_MAX, VALUE_MAX));
        send_word(make_bracket(0, 0));
        send_word(make_bracket(-1, ROOT_RAW));
        send_word(make_bracket(ROOT_RAW - 1, ROOT_RAW));
        send_word(make_bracket(ROOT_RAW, ROOT_RAW - 1));
        send_word(make_bracket(ROOT_RAW - 30, ROOT_RAW + 20));
        send_word(make_bracket(ROOT_RAW - 36, ROOT_RAW + 30));
        send_word(make_bracket(ROOT_RAW - 35, ROOT_RAW + 30));
        send_word(make_bracket(65536, 131072));
        send_word(make_bracket(200000, 300000));
        send_word(make_bracket(-100000, -5));
        send_word(make_bracket(VALUE_MIN, ROOT_RAW));
        send_word(make_bracket(ROOT_RAW - 1, VALUE_MAX));
        drain();
    endtask

    // smallest, largest and zero tolerance, including the step limit
    task automatic test_tolerance_extremes();
        set_tolerance(24'd1);
        send_word(make_bracket(ROOT_RAW - 1, ROOT_RAW));
        send_word(make_bracket(VALUE_MIN, VALUE_MAX));
        send_word(make_bracket(ROOT_RAW - 2, ROOT_RAW + 1));
        set_tolerance(24'hFFFFFF);
        send_word(make_bracket(VALUE_MIN, VALUE_MAX));
        send_word(make_bracket(0, VALUE_MAX));
        set_tolerance(24'd0);
        send_word(make_bracket(VALUE_MIN, VALUE_MAX));
        send_word(make_bracket(ROOT_RAW - 1, ROOT_RAW));
        send_word(make_bracket(0, 3 * 65536));
        drain();
    endtask

    task automatic test_random_traffic(int n_words, int idle_pct,
        logic [VALUE_WIDTH-1:0] tol);
        int gap;
        set_tolerance(tol);
        for (int i = 0; i < n_words; i++)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                gap = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(1, 200);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            send_word(random_bracket());
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_brackets();
        test_tolerance_extremes();
        test_random_traffic(330, 19, VALUE_WIDTH'($urandom_range(1, 4096)));
        test_random_traffic(330, 79, VALUE_WIDTH'($urandom_range(0, 24'hFFFFFF)));
        test_random_traffic(340, 0, TOL_RESET);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("cubic_bisection_root regression: pass");
        else
            $display("cubic_bisection_root regression: fail");
        $finish;
    end

endmodule
